FILE: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
  localparam int MaxBlocks = 16;
  localparam int IdxBits = 4;
  localparam int CntBits = 5;
  localparam int AddrBits = 24;
  localparam int SizeBits = 25;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StReject = 2'd2;
  localparam logic [1:0] StBadAddr = 2'd3;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;

  localparam logic CfgPool = 1'b0;
  localparam logic CfgEnable = 1'b1;

  typedef struct packed {
    logic opcode;
    logic [23:0] request_bytes;
    logic [23:0] user_address;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [23:0] granted_address;
    logic [24:0] granted_bytes;
    logic [24:0] bytes_in_use;
    logic [24:0] free_bytes;
    logic [31:0] alloc_total;
    logic [31:0] free_total;
  } rsp_t;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [SizeBits-1:0] size;
    logic used;
  } entry_t;
endpackage
`default_nettype wire

FILE: rtl/ffba_table.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic init_i,
  input  wire logic [ffba_pkg::SizeBits-1:0] init_size_i,
  input  wire logic [ffba_pkg::IdxBits-1:0] rd_idx_i,
  output ffba_pkg::entry_t rd_o,
  input  wire logic we_i,
  input  wire logic [ffba_pkg::IdxBits-1:0] wr_idx_i,
  input  wire ffba_pkg::entry_t wr_i
);
  ffba_pkg::entry_t ent_q [ffba_pkg::MaxBlocks];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q[0] <= '{start: '0, size: ffba_pkg::SizeBits'(1 << ffba_pkg::AddrBits),
                    used: 1'b0};
      for (int i = 1; i < ffba_pkg::MaxBlocks; i++) begin
        ent_q[i] <= '0;
      end
    end else if (init_i) begin
      ent_q[0] <= '{start: '0, size: init_size_i, used: 1'b0};
    end else if (we_i) begin
      ent_q[wr_idx_i] <= wr_i;
    end
  end

  assign rd_o = ent_q[rd_idx_i];
endmodule
`default_nettype wire

FILE: rtl/first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                         Direction
// request   start_i, busy_o, req_i        in
// result    done_o, rsp_o                 out
// config    cfg_we_i, cfg_idx_i, cfg_data_i in
// An allocate scans entries one per cycle, then shifts entries up one per cycle for a
// split; a free scans, then shifts entries down one per cycle for each merge.
// busy_o stays high while a transaction runs; its length is set by the single table port,
// and the worst case is a free that merges on both sides in a full table.
// done_o is high for the first cycle after busy_o falls and cannot be stalled.
// Reset builds one free block over the whole pool.
module first_fit_block_allocator_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic busy_o,
  input  wire ffba_pkg::req_t req_i,
  output logic done_o,
  output ffba_pkg::rsp_t rsp_o,
  input  wire logic cfg_we_i,
  input  wire logic cfg_idx_i,
  input  wire logic [24:0] cfg_data_i
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SSplit = 3'd2;
  localparam logic [2:0] SMerge = 3'd3;
  localparam logic [2:0] SPrev = 3'd4;
  localparam logic [2:0] SDone = 3'd5;
  localparam logic [2:0] SNext = 3'd6;

  localparam int IB = ffba_pkg::IdxBits;
  localparam int SB = ffba_pkg::SizeBits;
  localparam int AB = ffba_pkg::AddrBits;

  logic [2:0] state_q, state_d;
  logic [ffba_pkg::CntBits-1:0] count_q, count_d;
  logic [ffba_pkg::CntBits-1:0] idx_q, idx_d;
  logic [IB-1:0] hit_q, hit_d;
  logic [SB-1:0] need_q, need_d, pool_q, pool_d, held_q, held_d;
  logic enable_q, enable_d, op_q, op_d;
  logic [23:0] ua_q, ua_d;
  logic [31:0] acnt_q, acnt_d, fcnt_q, fcnt_d;
  ffba_pkg::entry_t hold_q, hold_d, rd;
  logic [IB-1:0] rd_idx, wr_idx;
  logic we;
  ffba_pkg::entry_t wr;
  ffba_pkg::rsp_t rsp_q, rsp_d;
  logic done_q, done_d, init;
  logic [SB-1:0] init_size, pool_v;
  logic [SB:0] need_full;
  logic [AB-1:0] user_of;

  ffba_table u_table (
    .clk_i, .rst_ni, .init_i(init), .init_size_i(init_size),
    .rd_idx_i(rd_idx), .rd_o(rd), .we_i(we), .wr_idx_i(wr_idx), .wr_i(wr)
  );

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  always_comb begin
    pool_v = {cfg_data_i[24:3], 3'b000};
    if (pool_v > SB'(1 << AB)) pool_v = SB'(1 << AB);
    init = cfg_we_i && (cfg_idx_i == ffba_pkg::CfgPool);
    init_size = pool_v;
    need_full = {1'b0, SB'(req_i.request_bytes)} + (SB+1)'(23);
    need_full[2:0] = 3'b000;
    if (need_full < (SB+1)'(32)) need_full = (SB+1)'(32);
    user_of = rd.start + AB'(16);
  end

  always_comb begin
    state_d = state_q; count_d = count_q; idx_d = idx_q; hit_d = hit_q;
    need_d = need_q; pool_d = pool_q; held_d = held_q; enable_d = enable_q;
    op_d = op_q; ua_d = ua_q; acnt_d = acnt_q; fcnt_d = fcnt_q;
    hold_d = hold_q; rsp_d = rsp_q; done_d = 1'b0;
    rd_idx = idx_q[IB-1:0]; wr_idx = idx_q[IB-1:0]; we = 1'b0; wr = rd;
    if (init) begin
      pool_d = pool_v; held_d = SB'(16); count_d = ffba_pkg::CntBits'(1);
    end
    if (cfg_we_i && cfg_idx_i == ffba_pkg::CfgEnable) enable_d = cfg_data_i[0];
    case (state_q)
      SIdle: begin
        if (start_i) begin
          op_d = req_i.opcode; ua_d = req_i.user_address;
          need_d = need_full[SB-1:0]; idx_d = '0;
          rsp_d = '0;
          if (!enable_q || (req_i.opcode == ffba_pkg::OpAlloc &&
              req_i.request_bytes == '0)) begin
            rsp_d.status = ffba_pkg::StReject; state_d = SDone;
          end else begin
            state_d = SScan;
          end
        end
      end
      SScan: begin
        if (idx_q >= count_q) begin
          rsp_d.status = (op_q == ffba_pkg::OpAlloc) ? ffba_pkg::StNoFit
                                                      : ffba_pkg::StBadAddr;
          state_d = SDone;
        end else if (op_q == ffba_pkg::OpAlloc) begin
          if (!rd.used && rd.size >= need_q) begin
            hit_d = idx_q[IB-1:0]; acnt_d = acnt_q + 32'd1;
            rsp_d.status = ffba_pkg::StOk;
            rsp_d.granted_address = rd.start + AB'(16);
            we = 1'b1; wr.used = 1'b1;
            if ({1'b0, rd.size} >= {1'b0, need_q} + (SB+1)'(32) &&
                count_q < ffba_pkg::CntBits'(ffba_pkg::MaxBlocks)) begin
              wr.size = need_q;
              hold_d = '{start: rd.start + AB'(need_q), size: rd.size - need_q,
                         used: 1'b0};
              held_d = held_q + need_q; rsp_d.granted_bytes = need_q;
              idx_d = count_q - 1'b1;
              count_d = count_q + 1'b1;
              state_d = SSplit;
            end else begin
              held_d = held_q + rd.size; rsp_d.granted_bytes = rd.size;
              state_d = SDone;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          if (rd.used && user_of == ua_q) begin
            hit_d = idx_q[IB-1:0]; fcnt_d = fcnt_q + 32'd1;
            rsp_d.status = ffba_pkg::StOk; rsp_d.granted_bytes = rd.size;
            if (held_q >= rd.size) held_d = held_q - rd.size;
            we = 1'b1; wr.used = 1'b0; hold_d = rd; hold_d.used = 1'b0;
            idx_d = idx_q + 1'b1;
            state_d = SNext;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      SSplit: begin
        // Move entry idx up by one until the slot after the hit is reached.
        if (idx_q == {1'b0, hit_q}) begin
          we = 1'b1; wr_idx = hit_q + 1'b1; wr = hold_q; state_d = SDone;
        end else begin
          we = 1'b1; wr_idx = IB'(idx_q + 1'b1); wr = rd; idx_d = idx_q - 1'b1;
        end
      end
      SNext: begin
        if (idx_q < count_q && !rd.used &&
            hold_q.start + AB'(hold_q.size) == rd.start) begin
          hold_d.size = hold_q.size + rd.size;
          we = 1'b1; wr_idx = hit_q; wr = hold_q; wr.size = hold_q.size + rd.size;
          idx_d = idx_q + 1'b1; count_d = count_q - 1'b1;
          state_d = SMerge;
        end else begin
          idx_d = {1'b0, hit_q} - 1'b1; state_d = SPrev;
        end
      end
      SMerge: begin
        // Shift entries down by one over the removed slot.
        if (idx_q > count_q) begin
          idx_d = {1'b0, hit_q} - 1'b1; state_d = SPrev;
        end else begin
          we = 1'b1; wr_idx = IB'(idx_q - 1'b1); wr = rd; idx_d = idx_q + 1'b1;
        end
      end
      SPrev: begin
        if (hit_q != '0 && !rd.used && rd.start + AB'(rd.size) == hold_q.start) begin
          we = 1'b1; wr_idx = hit_q - 1'b1; wr = rd; wr.size = rd.size + hold_q.size;
          hit_d = hit_q - 1'b1; idx_d = {1'b0, hit_q} + 1'b1;
          count_d = count_q - 1'b1; state_d = SMerge;
          hold_d.start = '1;
        end else begin
          state_d = SDone;
        end
      end
      SDone: begin
        rsp_d.bytes_in_use = held_q;
        rsp_d.free_bytes = (pool_q > held_q) ? pool_q - held_q : '0;
        rsp_d.alloc_total = acnt_q; rsp_d.free_total = fcnt_q;
        if (rsp_q.status != ffba_pkg::StOk) begin
          rsp_d.granted_address = '0; rsp_d.granted_bytes = '0;
        end
        if (op_q == ffba_pkg::OpFree) rsp_d.granted_address = '0;
        done_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; count_q <= ffba_pkg::CntBits'(1); idx_q <= '0; hit_q <= '0;
      pool_q <= SB'(1 << AB); held_q <= SB'(16); enable_q <= 1'b1;
      acnt_q <= '0; fcnt_q <= '0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; idx_q <= idx_d; hit_q <= hit_d;
      pool_q <= pool_d; held_q <= held_d; enable_q <= enable_d;
      acnt_q <= acnt_d; fcnt_q <= fcnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q <= need_d; op_q <= op_d; ua_q <= ua_d; hold_q <= hold_d; rsp_q <= rsp_d;
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= ffba_pkg::CntBits'(ffba_pkg::MaxBlocks))
    else $error("table count out of range");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o)) else $error("start lost");
endmodule
`default_nettype wire
